>>> hdl/sitd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_pkg: shared constants and types for the decimal text converter
// Sizes of the binary-to-BCD datapath, character codes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sitd_pkg;

  // Width of the two's complement input that is converted
  localparam int WIDTH = 32;
  // Width of the value port
  localparam int IN_W  = 32;
  localparam int VEXT_W = (WIDTH > IN_W) ? WIDTH : IN_W;

  // Decimal digits needed for a WIDTH-bit magnitude
  localparam int NDIG  = (WIDTH * 301) / 1000 + 1;
  // Bits shifted into the BCD register per conversion step
  localparam int BPS   = 4;
  localparam int NSTEP = (WIDTH + BPS - 1) / BPS;
  localparam int MAG_W = NSTEP * BPS;
  localparam int STP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int DIG_W = $clog2(NDIG);

  // Output field widths
  localparam int CHAR_W = 6;
  localparam int LEN_W  = 4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  typedef logic [NDIG-1:0][3:0] bcd_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic latch_len;
    logic emit_sign;
    logic emit_digit;
  } sitd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic neg;
    logic step_last;
    logic digit_last;
  } sitd_sts_t;

endpackage

>>> hdl/sitd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_ctrl: sequencing state machine
// Loads a word, runs the BCD conversion steps, sizes the run, then steps
// through the sign and digit characters one per cycle.
// ----------------------------------------------------------------------------
module sitd_ctrl
  import sitd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sitd_sts_t sts_i,
  output sitd_cmd_t cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.latch_len = 1'b1;
        state_d         = sts_i.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = S_DIGIT;
      end
      S_DIGIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.digit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hdl/sitd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_dp: conversion datapath
// Sign/magnitude split, shift-and-add-3 binary to BCD (BPS bits a step),
// leading digit search and the registered character output.
// ----------------------------------------------------------------------------
module sitd_dp
  import sitd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [IN_W-1:0] value_i,
  input  sitd_cmd_t         cmd_i,
  output sitd_sts_t         sts_o,
  output logic              valid_o,
  output logic [CHAR_W-1:0] character_o,
  output logic              last_o,
  output logic [LEN_W-1:0]  total_length_o
);

  logic [VEXT_W-1:0] val_ext;
  logic [WIDTH-1:0]  val_w, mag_w;
  logic              neg_w;

  logic [MAG_W-1:0]  mag_q, mag_d;
  bcd_t              bcd_q, bcd_d;
  logic [4*NDIG-1:0] bcd_sh;
  logic              neg_q;
  logic [STP_W-1:0]  step_q;
  logic [DIG_W-1:0]  pos_q;
  logic [DIG_W-1:0]  top_idx;
  logic [DIG_W:0]    len_sum;
  logic [LEN_W-1:0]  total_q;

  logic              valid_q, last_q;
  logic [CHAR_W-1:0] char_q;

  // Sign and magnitude of the low WIDTH bits
  assign val_ext = VEXT_W'(value_i);
  assign val_w   = val_ext[WIDTH-1:0];
  assign neg_w   = val_w[WIDTH-1];
  assign mag_w   = neg_w ? (~val_w + WIDTH'(1)) : val_w;

  // BPS rounds of add-3 then shift
  always_comb begin
    bcd_d  = bcd_q;
    mag_d  = mag_q;
    bcd_sh = '0;
    for (int b = 0; b < BPS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_d[d] >= 4'd5) begin
          bcd_d[d] = bcd_d[d] + 4'd3;
        end
      end
      bcd_sh = bcd_d;
      bcd_sh = {bcd_sh[4*NDIG-2:0], mag_d[MAG_W-1]};
      bcd_d  = bcd_sh;
      mag_d  = {mag_d[MAG_W-2:0], 1'b0};
    end
  end

  // Index of the most significant nonzero digit, zero if all are zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[d] != 4'd0) begin
        top_idx = DIG_W'(d);
      end
    end
  end

  assign len_sum = {1'b0, top_idx} + (DIG_W+1)'(1) + (DIG_W+1)'(neg_q);

  // Conversion registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= MAG_W'(mag_w);
      bcd_q  <= '0;
      neg_q  <= neg_w;
      step_q <= '0;
    end else if (cmd_i.step) begin
      mag_q  <= mag_d;
      bcd_q  <= bcd_d;
      step_q <= step_q + STP_W'(1);
    end
    if (cmd_i.latch_len) begin
      pos_q   <= top_idx;
      total_q <= LEN_W'(len_sum);
    end else if (cmd_i.emit_digit) begin
      pos_q   <= pos_q - DIG_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_sign | cmd_i.emit_digit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= CH_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= CH_ZERO + CHAR_W'(bcd_q[pos_q]);
      last_q <= (pos_q == '0);
    end
  end

  assign sts_o.neg        = neg_q;
  assign sts_o.step_last  = (step_q == STP_W'(NSTEP - 1));
  assign sts_o.digit_last = (pos_q == '0);

  assign valid_o        = valid_q;
  assign character_o    = char_q;
  assign last_o         = last_q;
  assign total_length_o = total_q;

endmodule

>>> hdl/signed_int_to_decimal_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_top: signed integer to decimal ASCII text
// Usage:
//   Drive value_i and raise start_i; the word is taken at a clock edge
//   where start_i is high and busy_o is low. busy_o stays high until the
//   last character has been issued.
//   Each character appears for one cycle with valid_o high: '-' first for
//   a negative value, then the digits most significant first, no leading
//   zeros. total_length_o holds the run length on every character and
//   last_o marks the final one.
//   Sequence: NSTEP (8) shift-and-add-3 steps of 4 bits each, a state to
//   size the run, then one character per cycle through the registered
//   output. A new word is taken only once the run is over.
//   The receiver cannot stall: characters are issued unconditionally.
//   Reset (rst_ni low, asynchronous) returns to idle and drops valid_o;
//   a run in progress is abandoned.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_top
  import sitd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [IN_W-1:0] value_i,
  output logic                   valid_o,
  output logic [CHAR_W-1:0]      character_o,
  output logic                   last_o,
  output logic [LEN_W-1:0]       total_length_o
);

  sitd_cmd_t cmd;
  sitd_sts_t sts;

  sitd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  sitd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .valid_o        (valid_o),
    .character_o    (character_o),
    .last_o         (last_o),
    .total_length_o (total_length_o)
  );

endmodule

>>> hdl/sitd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_checker: port-level checks for the decimal text converter
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sitd_checker
  import sitd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              valid_o,
  input logic [CHAR_W-1:0] character_o,
  input logic              last_o,
  input logic [LEN_W-1:0]  total_length_o
);

  // Only minus or decimal digits are issued
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (character_o == CH_MINUS) ||
                ((character_o >= CH_ZERO) && (character_o <= CH_ZERO + 6'd9)))
    else $error("character outside minus/digit set");

  // The sign never ends a run
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && character_o == CH_MINUS) |-> !last_o)
    else $error("minus sign marked last");

  // Characters of one run come back to back with a steady length
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (valid_o && $stable(total_length_o)))
    else $error("run broken or length changed mid-run");

  // An accepted word makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted word");

  // A run in progress keeps the block busy
  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o)
    else $error("block idle with characters pending");

endmodule

bind signed_int_to_decimal_text_top sitd_checker u_sitd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .character_o    (character_o),
  .last_o         (last_o),
  .total_length_o (total_length_o)
);
